### src/ttt_pkg.sv
// Shared types, codes and constants for the two-tier timer table.
`timescale 1ns / 1ps

package ttt_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int SLOT_NUM_W = 4;
  localparam int COUNT_W = 16;
  localparam int PERIOD_W = 8;
  localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST = 8'd10;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_QUICK_TICK = 2'd2,
    OP_SLOW_TICK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               one_shot;
    logic [COUNT_W-1:0] timeout;
    logic [COUNT_W-1:0] elapsed;
  } entry_t;

  typedef struct packed {
    logic               valid;
    logic               tier;
    logic               expire;
    logic               wr;
    logic [COUNT_W-1:0] elapsed;
  } upd_t;

endpackage

### src/ttt_slot_mem.sv
// Slot entry memory: one write port and one registered read port.
`timescale 1ns / 1ps

module ttt_slot_mem #(
  parameter int NUM_SLOTS = ttt_pkg::NUM_SLOTS_DEF,
  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  ttt_pkg::entry_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output ttt_pkg::entry_t rd_data
);
  import ttt_pkg::*;

  entry_t mem [NUM_SLOTS];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### src/ttt_slot_unit.sv
// Shared update unit: advances one slot for a quick or a slow tick.
`timescale 1ns / 1ps

module ttt_slot_unit (
  input  ttt_pkg::entry_t              entry,
  input  logic                         valid_in,
  input  logic                         tier_in,
  input  logic                         quick,
  input  logic [ttt_pkg::PERIOD_W-1:0] slow_period,
  output ttt_pkg::upd_t                upd
);
  import ttt_pkg::*;

  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] sat;
  logic [COUNT_W-1:0] remain;
  logic [COUNT_W-1:0] period_ext;

  assign period_ext = {{(COUNT_W-PERIOD_W){1'b0}}, slow_period};

  always_comb begin
    if (quick) begin
      sum = {1'b0, entry.elapsed} + (COUNT_W+1)'(1);
    end else begin
      sum = {1'b0, entry.elapsed} + {1'b0, period_ext};
    end
    sat = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
    remain = (entry.timeout > sat) ? (entry.timeout - sat) : '0;

    upd.valid   = valid_in;
    upd.tier    = tier_in;
    upd.expire  = 1'b0;
    upd.wr      = 1'b0;
    upd.elapsed = sat;

    if (quick) begin
      if (valid_in && !tier_in) begin
        upd.wr = 1'b1;
        if (sat >= entry.timeout) begin
          upd.expire = 1'b1;
          if (entry.one_shot) begin
            upd.valid = 1'b0;
            upd.wr    = 1'b0;
          end else begin
            upd.elapsed = '0;
            upd.tier    = entry.timeout > period_ext;
          end
        end
      end
    end else begin
      if (valid_in && tier_in) begin
        upd.wr = 1'b1;
        if (remain <= period_ext) begin
          upd.tier = 1'b0;
        end
      end
    end
  end

endmodule

### src/two_tier_timer_table_top.sv
// Top level of the two-tier timer table: sequencer, slot flags and result stage.
`timescale 1ns / 1ps

// Usage. A command beat is taken at a rising edge with start high and busy
// low. Register and unregister take effect as the beat is taken and give no
// result. A quick or slow tick walks the slots in ascending order, one slot
// per cycle through the shared update unit, so busy stays high through the
// walk and its closing state once the tick is taken. Each slot that expires
// on a quick tick gives one result beat: out_valid is high for one cycle
// with out_expired_slot, and out_last marks the final expiry of that tick.
// The final beat appears in the cycle in which busy falls, possibly while a
// new command is being taken. A tick with no expiry gives no beat. The
// receiver cannot stall: every beat is taken as it stands. The slow period
// is written over the cfg channel, which is ready only while the block is
// idle. Reset frees every slot, puts all slots in the quick tier and loads
// a slow period of ten; entry memory needs no clearing.
module two_tier_timer_table_top #(
  parameter int NUM_SLOTS = ttt_pkg::NUM_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_operation,
  input  logic [ttt_pkg::SLOT_NUM_W-1:0] in_slot,
  input  logic [ttt_pkg::COUNT_W-1:0]    in_timeout,
  input  logic                           in_one_shot,
  output logic                           out_valid,
  output logic [ttt_pkg::SLOT_NUM_W-1:0] out_expired_slot,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ttt_pkg::PERIOD_W-1:0]   cfg_slow_period
);
  import ttt_pkg::*;

  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_SLOTS - 1);

  state_t              state_r, state_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic                quick_r, quick_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic [SLOT_NUM_W-1:0] pend_slot_r, pend_slot_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SLOT_NUM_W-1:0] out_slot_r, out_slot_nxt;
  logic                out_last_r, out_last_nxt;
  logic [NUM_SLOTS-1:0] valid_r, valid_nxt;
  logic [NUM_SLOTS-1:0] tier_r, tier_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;

  logic     accept;
  logic     walking;
  logic     finishing;
  op_t      op;
  logic     in_range;
  logic [AW-1:0] in_addr;
  logic     mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  entry_t   mem_wr_data;
  logic [AW-1:0] mem_rd_addr;
  entry_t   mem_rd_data;
  upd_t     upd;

  assign op       = op_t'(in_operation);
  assign in_range = {3'b000, in_slot} < 7'(NUM_SLOTS);
  assign in_addr  = AW'(in_slot);

  ttt_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  ttt_slot_unit u_unit (
    .entry       (mem_rd_data),
    .valid_in    (valid_r[idx_r]),
    .tier_in     (tier_r[idx_r]),
    .quick       (quick_r),
    .slow_period (period_r),
    .upd         (upd)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && (op == OP_QUICK_TICK || op == OP_SLOW_TICK)) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    cfg_ready = 1'b0;
    walking   = 1'b0;
    finishing = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy      = 1'b0;
        cfg_ready = 1'b1;
      end
      ST_WALK: walking   = 1'b1;
      ST_DONE: finishing = 1'b1;
      default: busy      = 1'b1;
    endcase
  end

  assign accept = start && !busy;

  always_comb begin
    idx_nxt       = idx_r;
    quick_nxt     = quick_r;
    pend_vld_nxt  = pend_vld_r;
    pend_slot_nxt = pend_slot_r;
    out_valid_nxt = 1'b0;
    out_slot_nxt  = out_slot_r;
    out_last_nxt  = 1'b0;
    valid_nxt     = valid_r;
    tier_nxt      = tier_r;
    period_nxt    = period_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = idx_r;
    mem_wr_data   = '{one_shot: mem_rd_data.one_shot,
                      timeout:  mem_rd_data.timeout,
                      elapsed:  upd.elapsed};
    mem_rd_addr   = '0;

    if (cfg_valid && cfg_ready) begin
      period_nxt = cfg_slow_period;
    end

    if (accept) begin
      idx_nxt   = '0;
      quick_nxt = (op == OP_QUICK_TICK);
      case (op)
        OP_REGISTER: begin
          if (in_range) begin
            mem_wr_en          = 1'b1;
            mem_wr_addr        = in_addr;
            mem_wr_data        = '{one_shot: in_one_shot, timeout: in_timeout,
                                   elapsed: '0};
            valid_nxt[in_addr] = 1'b1;
            tier_nxt[in_addr]  = in_timeout > {{(COUNT_W-PERIOD_W){1'b0}}, period_r};
          end
        end
        OP_UNREGISTER: begin
          if (in_range) begin
            valid_nxt[in_addr] = 1'b0;
          end
        end
        default: ;
      endcase
    end

    if (walking) begin
      mem_rd_addr     = (idx_r == LAST_IDX) ? '0 : idx_r + AW'(1);
      idx_nxt         = (idx_r == LAST_IDX) ? idx_r : idx_r + AW'(1);
      mem_wr_en       = upd.wr;
      valid_nxt[idx_r] = upd.valid;
      tier_nxt[idx_r]  = upd.tier;
      if (upd.expire) begin
        if (pend_vld_r) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = pend_slot_r;
        end
        pend_vld_nxt  = 1'b1;
        pend_slot_nxt = SLOT_NUM_W'(idx_r);
      end
    end

    if (finishing && pend_vld_r) begin
      out_valid_nxt = 1'b1;
      out_slot_nxt  = pend_slot_r;
      out_last_nxt  = 1'b1;
      pend_vld_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      valid_r     <= '0;
      tier_r      <= '0;
      period_r    <= SLOW_PERIOD_RST;
      quick_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
      valid_r     <= valid_nxt;
      tier_r      <= tier_nxt;
      period_r    <= period_nxt;
      quick_r     <= quick_nxt;
    end
    idx_r       <= idx_nxt;
    pend_slot_r <= pend_slot_nxt;
    out_slot_r  <= out_slot_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_expired_slot = out_slot_r;
  assign out_last         = out_last_r;

  a_result_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == ST_WALK || $past(state_r) == ST_DONE)
    else $error("result beat outside a slot walk");

  a_result_on_quick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> quick_r)
    else $error("result beat during a slow tick");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |=> state_r == ST_IDLE)
    else $error("walk did not finish after its closing cycle");

  a_no_pending_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_vld_r)
    else $error("expiry left pending while idle");

  a_last_ends_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |=> !out_valid_r)
    else $error("result beat after the final expiry");

endmodule

### bench/tb_top.sv
// Self-checking bench for the two-tier timer table: command driver, beat monitor, expiry predictor.
`timescale 1ns / 1ps

module tb_top;
  import ttt_pkg::*;

  localparam int SLOTS = NUM_SLOTS_DEF;
  localparam int LAT = SLOTS + 4;

  typedef enum logic [1:0] {
    BEAT_CMD,
    BEAT_PERIOD,
    BEAT_DRAIN
  } beat_kind_t;

  typedef struct {
    beat_kind_t            kind;
    op_t                   op;
    logic [SLOT_NUM_W-1:0] slot;
    logic [COUNT_W-1:0]    timeout;
    logic                  one_shot;
    logic [PERIOD_W-1:0]   period;
    int                    gap;
  } pending_t;

  typedef struct {
    logic [SLOT_NUM_W-1:0] slot;
    logic                  last;
  } expiry_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            in_operation = OP_REGISTER;
  logic [SLOT_NUM_W-1:0] in_slot = '0;
  logic [COUNT_W-1:0]    in_timeout = '0;
  logic                  in_one_shot = 1'b0;
  logic                  out_valid;
  logic [SLOT_NUM_W-1:0] out_expired_slot;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [PERIOD_W-1:0]   cfg_slow_period = SLOW_PERIOD_RST;

  pending_t pending_q[$];
  expiry_t  expiry_q[$];
  int       errors = 0;
  int       quiet = 0;
  int       gap_count = 0;
  bit       no_idle = 1'b0;

  // Predicted table contents.
  logic [PERIOD_W-1:0] period_now = SLOW_PERIOD_RST;
  bit                  slot_used[SLOTS];
  bit                  slot_slow[SLOTS];
  int                  slot_limit[SLOTS];
  int                  slot_count[SLOTS];
  bit                  slot_once[SLOTS];

  two_tier_timer_table_top #(
    .NUM_SLOTS(SLOTS)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_slot         (in_slot),
    .in_timeout      (in_timeout),
    .in_one_shot     (in_one_shot),
    .out_valid       (out_valid),
    .out_expired_slot(out_expired_slot),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_slow_period (cfg_slow_period)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("%0t MISMATCH %s: got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic apply_command(input op_t op, input logic [SLOT_NUM_W-1:0] s,
                               input logic [COUNT_W-1:0] t, input logic once);
    int      hits[SLOTS];
    int      n;
    int      i;
    int      remain;
    expiry_t e;
    n = 0;
    case (op)
      OP_REGISTER: begin
        slot_used[s] = 1'b1;
        slot_limit[s] = int'(t);
        slot_count[s] = 0;
        slot_once[s] = once;
        slot_slow[s] = int'(t) > int'(period_now);
      end
      OP_UNREGISTER: slot_used[s] = 1'b0;
      OP_QUICK_TICK: begin
        for (i = 0; i < SLOTS; i++) begin
          if (!slot_used[i] || slot_slow[i]) continue;
          slot_count[i] = (slot_count[i] + 1 > 65535) ? 65535 : slot_count[i] + 1;
          if (slot_count[i] < slot_limit[i]) continue;
          hits[n] = i;
          n++;
          if (slot_once[i]) begin
            slot_used[i] = 1'b0;
            continue;
          end
          slot_count[i] = 0;
          if (slot_limit[i] > int'(period_now)) slot_slow[i] = 1'b1;
        end
        for (i = 0; i < n; i++) begin
          e.slot = hits[i][SLOT_NUM_W-1:0];
          e.last = (i == n - 1);
          expiry_q.push_back(e);
        end
      end
      default: begin
        for (i = 0; i < SLOTS; i++) begin
          if (!slot_used[i] || !slot_slow[i]) continue;
          slot_count[i] = slot_count[i] + int'(period_now);
          if (slot_count[i] > 65535) slot_count[i] = 65535;
          remain = (slot_limit[i] > slot_count[i]) ? slot_limit[i] - slot_count[i] : 0;
          if (remain <= int'(period_now)) slot_slow[i] = 1'b0;
        end
      end
    endcase
  endtask

  task automatic push_cmd(input op_t op, input int s, input int t, input int once);
    pending_t p;
    int       r;
    p.kind = BEAT_CMD;
    p.op = op;
    p.slot = s[SLOT_NUM_W-1:0];
    p.timeout = t[COUNT_W-1:0];
    p.one_shot = once[0];
    p.period = '0;
    if (no_idle) begin
      p.gap = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) p.gap = 0;
      else if (r < 85) p.gap = $urandom_range(1, 3);
      else if (r < 97) p.gap = $urandom_range(4, 12);
      else p.gap = $urandom_range(20, 60);
    end
    pending_q.push_back(p);
  endtask

  task automatic push_period(input int value);
    pending_t p;
    p.kind = BEAT_PERIOD;
    p.op = OP_REGISTER;
    p.slot = '0;
    p.timeout = '0;
    p.one_shot = 1'b0;
    p.period = value[PERIOD_W-1:0];
    p.gap = 0;
    pending_q.push_back(p);
  endtask

  task automatic push_drain();
    pending_t p;
    p.kind = BEAT_DRAIN;
    p.op = OP_REGISTER;
    p.slot = '0;
    p.timeout = '0;
    p.one_shot = 1'b0;
    p.period = '0;
    p.gap = 0;
    pending_q.push_back(p);
  endtask

  task automatic add_random_phase(input int period, input int count);
    int k;
    int pick;
    int sel;
    int t;
    push_period(period);
    for (k = 0; k < count; k++) begin
      if (k % 16 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (k == count / 2) push_drain();
      sel = $urandom_range(0, 19);
      if (sel < 10) t = $urandom_range(0, 3);
      else if (sel < 15) t = $urandom_range(0, 2 * period + 3);
      else if (sel < 18) t = period - 1 + $urandom_range(0, 2);
      else t = $urandom_range(0, 65535);
      if (t < 0) t = 0;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        push_cmd(OP_REGISTER, $urandom_range(0, 15), t, $urandom_range(0, 1));
      end else if (pick < 40) begin
        push_cmd(OP_UNREGISTER, $urandom_range(0, 15), $urandom_range(0, 65535),
                 $urandom_range(0, 1));
      end else if (pick < 85) begin
        push_cmd(OP_QUICK_TICK, $urandom_range(0, 15), $urandom_range(0, 65535),
                 $urandom_range(0, 1));
      end else begin
        push_cmd(OP_SLOW_TICK, $urandom_range(0, 15), $urandom_range(0, 65535),
                 $urandom_range(0, 1));
      end
    end
  endtask

  // Command driver: one beat at a time, configuration only once the table is quiet.
  always @(posedge clk) begin : driver
    logic     next_start;
    logic     next_cfg;
    pending_t head;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      gap_count = 0;
    end else begin
      next_start = start;
      next_cfg = cfg_valid;
      if (start && !busy) begin
        apply_command(op_t'(in_operation), in_slot, in_timeout, in_one_shot);
        next_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        period_now = cfg_slow_period;
        next_cfg = 1'b0;
      end
      if (!next_start && !next_cfg && pending_q.size() != 0) begin
        head = pending_q[0];
        case (head.kind)
          BEAT_CMD: begin
            if (gap_count < head.gap) begin
              gap_count++;
            end else begin
              void'(pending_q.pop_front());
              in_operation <= head.op;
              in_slot <= head.slot;
              in_timeout <= head.timeout;
              in_one_shot <= head.one_shot;
              next_start = 1'b1;
              gap_count = 0;
            end
          end
          BEAT_PERIOD: begin
            if (!start && quiet >= LAT) begin
              void'(pending_q.pop_front());
              cfg_slow_period <= head.period;
              next_cfg = 1'b1;
            end
          end
          default: begin
            if (!start && quiet >= 2) void'(pending_q.pop_front());
          end
        endcase
      end
      start <= next_start;
      cfg_valid <= next_cfg;
    end
  end

  // Result monitor.
  always @(posedge clk) begin : monitor
    expiry_t want;
    if (!rst_n) begin
      quiet <= 0;
    end else begin
      if (out_valid) begin
        if (expiry_q.size() == 0) begin
          report_mismatch("result beat with nothing pending", out_expired_slot, -1);
        end else begin
          want = expiry_q.pop_front();
          if (out_expired_slot !== want.slot)
            report_mismatch("expired_slot", out_expired_slot, want.slot);
          if (out_last !== want.last)
            report_mismatch("last", out_last, want.last);
        end
      end
      if (start || busy || out_valid || expiry_q.size() != 0) quiet <= 0;
      else if (quiet < 1000) quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    int waited;
    // Directed part at the reset period of ten.
    push_cmd(OP_REGISTER, 0, 0, 0);
    push_cmd(OP_REGISTER, 15, 65535, 1);
    push_cmd(OP_REGISTER, 2, 10, 0);
    push_cmd(OP_REGISTER, 3, 11, 1);
    push_cmd(OP_REGISTER, 5, 1, 1);
    push_cmd(OP_QUICK_TICK, 15, 16'hFFFF, 1);
    push_cmd(OP_SLOW_TICK, 0, 0, 0);
    push_cmd(OP_QUICK_TICK, 0, 0, 0);
    push_cmd(OP_QUICK_TICK, 0, 0, 0);
    push_cmd(OP_REGISTER, 0, 5, 1);
    push_cmd(OP_UNREGISTER, 9, 0, 0);
    push_cmd(OP_UNREGISTER, 15, 0, 0);
    push_cmd(OP_QUICK_TICK, 0, 0, 0);
    push_cmd(OP_SLOW_TICK, 0, 0, 0);
    // A zero period: slow ticks add nothing.
    push_period(0);
    push_cmd(OP_REGISTER, 4, 0, 1);
    push_cmd(OP_REGISTER, 6, 1, 0);
    push_cmd(OP_SLOW_TICK, 0, 0, 0);
    push_cmd(OP_QUICK_TICK, 0, 0, 0);
    // A longer period than the slot's count has left: it drops to the quick tier.
    push_period(3);
    push_cmd(OP_REGISTER, 8, 20, 0);
    push_period(100);
    push_cmd(OP_SLOW_TICK, 0, 0, 0);
    push_cmd(OP_QUICK_TICK, 0, 0, 0);
    push_cmd(OP_QUICK_TICK, 0, 0, 0);
    push_drain();
    add_random_phase(255, 52);
    add_random_phase(1, 52);
    add_random_phase($urandom_range(2, 254), 52);
    add_random_phase(0, 52);
    add_random_phase(10, 52);
    add_random_phase($urandom_range(2, 30), 52);

    while (pending_q.size() != 0 || start || cfg_valid) @(negedge clk);
    waited = 0;
    while (expiry_q.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (LAT) @(negedge clk);
    if (expiry_q.size() != 0)
      report_mismatch("result beats never arrived", 0, expiry_q.size());
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
